### hdl/vlmf_pkg.sv
// Shared types, constants and helper functions for the variable-length message FIFO.
package vlmf_pkg;

  localparam int QUEUE_WORDS   = 1024;
  localparam int ADDR_W        = $clog2(QUEUE_WORDS);
  localparam int SIZE_W        = 11;
  localparam int MAX_MSG_BYTES = 256;
  localparam int LEN_W         = 9;
  localparam int NW_W          = LEN_W - 1;
  localparam int WCNT_W        = $clog2(MAX_MSG_BYTES / 4 + 1);
  localparam int WORD_W        = 32;
  localparam int VM_W          = 4;
  localparam int ST_W          = 3;
  localparam int FN_W          = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 11;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ACCESS   = 3'd1;
  localparam logic [ST_W-1:0] ST_LONG     = 3'd2;
  localparam logic [ST_W-1:0] ST_SPACE    = 3'd3;
  localparam logic [ST_W-1:0] ST_INACTIVE = 3'd4;

  localparam logic [FN_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FN_W-1:0] FN_READ  = 2'd1;
  localparam logic [FN_W-1:0] FN_DEACT = 2'd2;
  localparam logic [FN_W-1:0] FN_INIT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_QSIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ACT = 3'd4;

  localparam logic [SIZE_W-1:0] QSIZE_RST   = 11'd256;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST = 9'd256;
  localparam logic [VM_W-1:0]   WRITER_RST  = 4'd1;
  localparam logic [VM_W-1:0]   READER_RST  = 4'd1;
  localparam logic              INIT_ACT_RST = 1'b0;

  typedef struct packed {
    logic [FN_W-1:0]   func;
    logic [VM_W-1:0]   caller_vm;
    logic              via_hypercall;
    logic [LEN_W-1:0]  msg_len;
    logic [WORD_W-1:0] data_word;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  out_len;
    logic [WORD_W-1:0] out_word;
    logic              out_last;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [LEN_W-1:0]  max_len;
    logic [VM_W-1:0]   writer_vm;
    logic [VM_W-1:0]   reader_vm;
    logic              init_active;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx,
                                                 input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = SIZE_W'(idx) + 1'b1;
    return (n >= size) ? '0 : n[ADDR_W-1:0];
  endfunction

  function automatic logic [NW_W-1:0] words_of(input logic [LEN_W-1:0] len);
    logic [LEN_W:0] s;
    s = {1'b0, len} + (LEN_W+1)'(3);
    return s[LEN_W:2];
  endfunction

endpackage

### hdl/vlmf_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module vlmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/vlmf_cfg.sv
// Configuration registers with range clamping of queue size and length limit.
module vlmf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vlmf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vlmf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output vlmf_pkg::cfg_t                   cfg_o
);

  logic [vlmf_pkg::SIZE_W-1:0] qsize_q;
  logic [vlmf_pkg::LEN_W-1:0]  max_len_q;
  logic [vlmf_pkg::VM_W-1:0]   writer_q;
  logic [vlmf_pkg::VM_W-1:0]   reader_q;
  logic                        init_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qsize_q    <= vlmf_pkg::QSIZE_RST;
      max_len_q  <= vlmf_pkg::MAX_LEN_RST;
      writer_q   <= vlmf_pkg::WRITER_RST;
      reader_q   <= vlmf_pkg::READER_RST;
      init_act_q <= vlmf_pkg::INIT_ACT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vlmf_pkg::CFG_QSIZE:    qsize_q    <= cfg_wdata_i[vlmf_pkg::SIZE_W-1:0];
        vlmf_pkg::CFG_MAX_LEN:  max_len_q  <= cfg_wdata_i[vlmf_pkg::LEN_W-1:0];
        vlmf_pkg::CFG_WRITER:   writer_q   <= cfg_wdata_i[vlmf_pkg::VM_W-1:0];
        vlmf_pkg::CFG_READER:   reader_q   <= cfg_wdata_i[vlmf_pkg::VM_W-1:0];
        vlmf_pkg::CFG_INIT_ACT: init_act_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (qsize_q < vlmf_pkg::SIZE_W'(2)) begin
      cfg_o.size = vlmf_pkg::SIZE_W'(2);
    end else if (qsize_q > vlmf_pkg::SIZE_W'(vlmf_pkg::QUEUE_WORDS)) begin
      cfg_o.size = vlmf_pkg::SIZE_W'(vlmf_pkg::QUEUE_WORDS);
    end else begin
      cfg_o.size = qsize_q;
    end
    if (max_len_q > vlmf_pkg::LEN_W'(vlmf_pkg::MAX_MSG_BYTES)) begin
      cfg_o.max_len = vlmf_pkg::LEN_W'(vlmf_pkg::MAX_MSG_BYTES);
    end else begin
      cfg_o.max_len = max_len_q;
    end
    cfg_o.writer_vm   = writer_q;
    cfg_o.reader_vm   = reader_q;
    cfg_o.init_active = init_act_q;
  end

endmodule

### hdl/vlmf_ctrl.sv
// Queue sequencer: pointer state, store access sequencing and output register.
module vlmf_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vlmf_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  input  vlmf_pkg::in_item_t              in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output vlmf_pkg::out_item_t             out_data_o,
  input  logic                            out_stall_i,
  output vlmf_pkg::ram_req_t              ram_req_o,
  input  logic [vlmf_pkg::WORD_W-1:0]     ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMMIT,
    S_RHDR,
    S_RDATA
  } state_e;

  state_e                        state_q, state_d;
  logic [vlmf_pkg::ADDR_W-1:0]   head_q, head_d;
  logic [vlmf_pkg::ADDR_W-1:0]   tail_q, tail_d;
  logic [vlmf_pkg::ADDR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [vlmf_pkg::SIZE_W-1:0]   free_q, free_d;
  logic [vlmf_pkg::ADDR_W-1:0]   count_q, count_d;
  logic                          active_q, active_d;
  logic                          wip_q, wip_d;
  logic [vlmf_pkg::ST_W-1:0]     pend_q, pend_d;
  logic [vlmf_pkg::WCNT_W-1:0]   wleft_q, wleft_d;
  logic [vlmf_pkg::LEN_W-1:0]    wlen_q, wlen_d;
  logic [vlmf_pkg::LEN_W-1:0]    len_q, len_d;
  logic [vlmf_pkg::WCNT_W-1:0]   iss_q, iss_d;
  logic [vlmf_pkg::WCNT_W-1:0]   eleft_q, eleft_d;
  logic                          rd_pend_q, rd_pend_d;
  logic                          out_valid_q;
  vlmf_pkg::out_item_t           out_q;

  logic                          out_free;
  logic                          acc;
  logic                          emit;
  vlmf_pkg::out_item_t           emit_item;
  logic [vlmf_pkg::ST_W-1:0]     st;
  logic [vlmf_pkg::WCNT_W-1:0]   wl;
  logic [vlmf_pkg::ADDR_W-1:0]   wp;
  logic [vlmf_pkg::NW_W-1:0]     nw;
  logic [vlmf_pkg::LEN_W-1:0]    rlen;
  logic [vlmf_pkg::NW_W-1:0]     rnw;
  logic                          issue;
  logic                          load;

  function automatic logic [vlmf_pkg::SIZE_W-1:0] free_add(
      input logic [vlmf_pkg::SIZE_W-1:0] fw,
      input logic [vlmf_pkg::NW_W-1:0]   words,
      input logic [vlmf_pkg::SIZE_W-1:0] cap);
    logic [vlmf_pkg::SIZE_W:0] s;
    s = {1'b0, fw} + (vlmf_pkg::SIZE_W+1)'(words) + 1'b1;
    return (s > {1'b0, cap}) ? cap : s[vlmf_pkg::SIZE_W-1:0];
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign nw          = vlmf_pkg::words_of(in_data_i.msg_len);
  assign rlen        = (ram_rdata_i[vlmf_pkg::LEN_W-1:0] >
                        vlmf_pkg::LEN_W'(vlmf_pkg::MAX_MSG_BYTES)) ?
                       vlmf_pkg::LEN_W'(vlmf_pkg::MAX_MSG_BYTES) :
                       ram_rdata_i[vlmf_pkg::LEN_W-1:0];
  assign rnw         = vlmf_pkg::words_of(rlen);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    wr_ptr_d  = wr_ptr_q;
    free_d    = free_q;
    count_d   = count_q;
    active_d  = active_q;
    wip_d     = wip_q;
    pend_d    = pend_q;
    wleft_d   = wleft_q;
    wlen_d    = wlen_q;
    len_d     = len_q;
    iss_d     = iss_q;
    eleft_d   = eleft_q;
    rd_pend_d = rd_pend_q;
    ram_req_o = '0;
    emit      = 1'b0;
    emit_item = '0;
    emit_item.out_last = 1'b1;
    st        = pend_q;
    wl        = wleft_q;
    wp        = wr_ptr_q;
    issue     = 1'b0;
    load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_data_i.func)
            vlmf_pkg::FN_WRITE: begin
              if (!wip_q) begin
                wlen_d = in_data_i.msg_len;
                wl     = '0;
                wp     = vlmf_pkg::advance(tail_q, cfg_i.size);
                if (in_data_i.via_hypercall && in_data_i.caller_vm != cfg_i.writer_vm) begin
                  st = vlmf_pkg::ST_ACCESS;
                end else if (in_data_i.msg_len > cfg_i.max_len) begin
                  st = vlmf_pkg::ST_LONG;
                end else begin
                  active_d = 1'b1;
                  if ((vlmf_pkg::SIZE_W'(nw) + 1'b1) > free_q ||
                      count_q >= vlmf_pkg::ADDR_W'(vlmf_pkg::QUEUE_WORDS - 1)) begin
                    st = vlmf_pkg::ST_SPACE;
                  end else begin
                    st = vlmf_pkg::ST_OK;
                    wl = nw[vlmf_pkg::WCNT_W-1:0];
                  end
                end
              end
              if (st == vlmf_pkg::ST_OK && wl != '0) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = wp;
                ram_req_o.wdata = in_data_i.data_word;
                wp = vlmf_pkg::advance(wp, cfg_i.size);
                wl = wl - 1'b1;
              end
              wleft_d  = wl;
              wr_ptr_d = wp;
              if (in_data_i.last && st == vlmf_pkg::ST_OK) begin
                wip_d   = 1'b1;
                pend_d  = st;
                state_d = S_COMMIT;
              end else if (in_data_i.last) begin
                emit             = 1'b1;
                emit_item.status = st;
                wip_d            = 1'b0;
                pend_d           = vlmf_pkg::ST_OK;
              end else begin
                wip_d  = 1'b1;
                pend_d = st;
              end
            end
            vlmf_pkg::FN_READ: begin
              if (in_data_i.via_hypercall && in_data_i.caller_vm != cfg_i.reader_vm) begin
                emit             = 1'b1;
                emit_item.status = vlmf_pkg::ST_ACCESS;
              end else if (!active_q) begin
                emit             = 1'b1;
                emit_item.status = vlmf_pkg::ST_INACTIVE;
              end else if (count_q == '0) begin
                emit             = 1'b1;
                emit_item.status = vlmf_pkg::ST_SPACE;
              end else begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = head_q;
                state_d         = S_RHDR;
              end
            end
            vlmf_pkg::FN_DEACT: begin
              emit = 1'b1;
              if (in_data_i.via_hypercall && in_data_i.caller_vm != cfg_i.writer_vm) begin
                emit_item.status = vlmf_pkg::ST_ACCESS;
              end else begin
                active_d = 1'b0;
                head_d   = '0;
                tail_d   = '0;
                free_d   = cfg_i.size;
                count_d  = '0;
                wip_d    = 1'b0;
                pend_d   = vlmf_pkg::ST_OK;
                wr_ptr_d = '0;
                wleft_d  = '0;
              end
            end
            default: begin
              emit     = 1'b1;
              active_d = cfg_i.init_active;
              head_d   = '0;
              tail_d   = '0;
              free_d   = cfg_i.size;
              count_d  = '0;
              wip_d    = 1'b0;
              pend_d   = vlmf_pkg::ST_OK;
              wr_ptr_d = '0;
              wleft_d  = '0;
            end
          endcase
        end
      end
      S_COMMIT: begin
        // zero-fill missing words, then header and commit
        if (wleft_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = wr_ptr_q;
          ram_req_o.wdata = '0;
          wr_ptr_d = vlmf_pkg::advance(wr_ptr_q, cfg_i.size);
          wleft_d  = wleft_q - 1'b1;
        end else if (out_free) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = tail_q;
          ram_req_o.wdata = vlmf_pkg::WORD_W'(wlen_q);
          tail_d  = wr_ptr_q;
          if ((vlmf_pkg::SIZE_W'(vlmf_pkg::words_of(wlen_q)) + 1'b1) > free_q) begin
            free_d = '0;
          end else begin
            free_d = free_q - vlmf_pkg::SIZE_W'(vlmf_pkg::words_of(wlen_q)) - 1'b1;
          end
          count_d = count_q + 1'b1;
          emit    = 1'b1;
          wip_d   = 1'b0;
          pend_d  = vlmf_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      S_RHDR: begin
        if (rnw == '0) begin
          if (out_free) begin
            emit    = 1'b1;
            head_d  = vlmf_pkg::advance(head_q, cfg_i.size);
            free_d  = free_add(free_q, rnw, cfg_i.size);
            count_d = count_q - 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          len_d     = rlen;
          head_d    = vlmf_pkg::advance(head_q, cfg_i.size);
          iss_d     = rnw[vlmf_pkg::WCNT_W-1:0];
          eleft_d   = rnw[vlmf_pkg::WCNT_W-1:0];
          rd_pend_d = 1'b0;
          state_d   = S_RDATA;
        end
      end
      S_RDATA: begin
        issue = (iss_q != '0) && (!rd_pend_q || out_free);
        load  = rd_pend_q && out_free;
        if (issue) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = head_q;
          head_d = vlmf_pkg::advance(head_q, cfg_i.size);
          iss_d  = iss_q - 1'b1;
        end
        rd_pend_d = issue || (rd_pend_q && !out_free);
        if (load) begin
          emit               = 1'b1;
          emit_item.out_len  = len_q;
          emit_item.out_word = ram_rdata_i;
          emit_item.out_last = (eleft_q == vlmf_pkg::WCNT_W'(1));
          eleft_d            = eleft_q - 1'b1;
          if (eleft_q == vlmf_pkg::WCNT_W'(1)) begin
            free_d  = free_add(free_q, vlmf_pkg::words_of(len_q), cfg_i.size);
            count_d = count_q - 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      wr_ptr_q    <= '0;
      free_q      <= vlmf_pkg::QSIZE_RST;
      count_q     <= '0;
      active_q    <= vlmf_pkg::INIT_ACT_RST;
      wip_q       <= 1'b0;
      pend_q      <= vlmf_pkg::ST_OK;
      wleft_q     <= '0;
      wlen_q      <= '0;
      len_q       <= '0;
      iss_q       <= '0;
      eleft_q     <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      wr_ptr_q  <= wr_ptr_d;
      free_q    <= free_d;
      count_q   <= count_d;
      active_q  <= active_d;
      wip_q     <= wip_d;
      pend_q    <= pend_d;
      wleft_q   <= wleft_d;
      wlen_q    <= wlen_d;
      len_q     <= len_d;
      iss_q     <= iss_d;
      eleft_q   <= eleft_d;
      rd_pend_q <= rd_pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= emit_item;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### hdl/variable_length_message_fifo_top.sv
// Top level of the variable-length message FIFO: config registers, sequencer and word store.
//
// One message queue kept in a 1024 x 32 circular word store with a length header per
// message. A write-word transaction makes at most one store write; after the closing word
// of an accepted write, the data words the run left out are stored as zero and then the
// header is written. A read issues the header read, decodes the header, then starts the
// word reads and returns the payload words, paced by the single registered read port of
// the store and by output stalls; a zero-length read ends after the header decode. Error
// results, deactivate and init are answered from the idle state. Input is taken only
// while the sequencer is idle and the output register is empty or being drained. The
// store has no reset and no clearing pass; entries are always written before being read.
module variable_length_message_fifo_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vlmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vlmf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  vlmf_pkg::in_item_t              in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output vlmf_pkg::out_item_t             out_data_o,
  input  logic                            out_stall_i
);

  vlmf_pkg::cfg_t                cfg;
  vlmf_pkg::ram_req_t            ram_req;
  logic [vlmf_pkg::WORD_W-1:0]   ram_rdata;

  vlmf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vlmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  vlmf_ram #(
    .WIDTH (vlmf_pkg::WORD_W),
    .DEPTH (vlmf_pkg::QUEUE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

### hdl/vlmf_checker.sv
// Port-level assertions for the variable-length message FIFO and their bind.
module vlmf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input vlmf_pkg::out_item_t out_data_o,
  input logic                out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != vlmf_pkg::ST_OK |->
      out_data_o.out_last && out_data_o.out_len == '0 && out_data_o.out_word == '0)
    else $error("error result carries payload");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_len <= vlmf_pkg::LEN_W'(vlmf_pkg::MAX_MSG_BYTES))
    else $error("read length beyond limit");

  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_last |->
      out_data_o.status == vlmf_pkg::ST_OK && out_data_o.out_len != '0)
    else $error("non-final result is not a payload word");

endmodule

bind variable_length_message_fifo_top vlmf_checker u_vlmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_data_o  (out_data_o),
  .out_stall_i (out_stall_i)
);
